/* src/evad_pkg.sv */
// ----------------------------------------------------------------------------
// evad_pkg
// shared widths, register indexes and reset values of the energy-based
// voice activity detector
// ----------------------------------------------------------------------------
package evad_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;   // square of a q1.15 sample, at most 2^30
    localparam int SUM_W      = 42;   // q12.30 window sum of squares
    localparam int WIN_W      = 13;
    localparam int HANG_W     = 20;
    localparam int HOLD_W     = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 42;

    localparam int MAX_WINDOW_DEFAULT = 4096;

    localparam logic [WIN_W-1:0]  WINDOW_LEN_RST   = 13'd160;
    localparam logic [HANG_W-1:0] HANGOVER_LEN_RST = 20'd8000;
    localparam logic [SUM_W-1:0]  ENERGY_LIMIT_RST = 42'd17179869;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN   = 2'd0,
        REG_HANGOVER_LEN = 2'd1,
        REG_ENERGY_LIMIT = 2'd2
    } cfg_reg_t;

endpackage

/* src/energy_voice_activity_detector.sv */
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// energy-based voice activity detector with hangover, one result per sample
// ----------------------------------------------------------------------------
// Each accepted sample gives exactly one result transaction carrying
// voice_start, voice_end and active. The block takes one sample per clock
// cycle while no result is stalled. Each sample lands in the input register;
// then the 16x16 square, the saturating window accumulate, the limit
// compare and the hangover update run as combinational logic between the
// input register and the result register, where they land. A stalled result
// freezes the whole pipe, and sample_stall follows from it in the same cycle.
// The squared-sum test sum >= energy_limit stands in for rms >= threshold,
// so program energy_limit as threshold^2 * window_len in q2.30 units. A window
// length of zero acts as one, a length above MAX_WINDOW acts as MAX_WINDOW,
// and the window sum saturates at 2^42 - 1. Registers are written through the
// cfg port (index 0 window_len, 1 hangover_len, 2 energy_limit, 3 ignored);
// cfg_ready is always high, and writes are meant for when the block is idle.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector #(
    parameter int MAX_WINDOW = evad_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // sample channel
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [evad_pkg::SAMPLE_W-1:0]   sample,

    // result channel
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic                                   voice_start,
    output logic                                   voice_end,
    output logic                                   active,

    // register write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [evad_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int WIN_W  = evad_pkg::WIN_W;
    localparam int SUM_W  = evad_pkg::SUM_W;
    localparam int SQ_W   = evad_pkg::SQ_W;
    localparam int HANG_W = evad_pkg::HANG_W;
    localparam int HOLD_W = evad_pkg::HOLD_W;

    // configuration registers
    logic [WIN_W-1:0]  window_len_reg;
    logic [HANG_W-1:0] hangover_len_reg;
    logic [SUM_W-1:0]  energy_limit_reg;

    // pipe control: everything moves unless a result is held back
    logic advance;

    // input register and square
    logic                                   in_valid_reg;
    logic signed [evad_pkg::SAMPLE_W-1:0]   sample_reg;
    logic signed [2*evad_pkg::SAMPLE_W-1:0] product;
    logic [SQ_W-1:0]                        sq;

    // detector state
    logic [SUM_W-1:0]  energy_sum_reg,  energy_sum_next;
    logic [WIN_W-1:0]  window_fill_reg, window_fill_next;
    logic [HOLD_W-1:0] hold_left_reg,   hold_left_next;
    logic              is_active_reg,   is_active_next;

    // result register
    logic result_valid_reg;
    logic voice_start_reg, voice_start_next;
    logic voice_end_reg,   voice_end_next;

    // accumulate and decide
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic [WIN_W-1:0] fill_inc;
    logic [WIN_W-1:0] win_eff;
    logic             window_done;
    logic             loud;

    assign advance      = !(result_valid_reg && result_stall);
    assign sample_stall = !advance;
    assign cfg_ready    = 1'b1;

    assign result_valid = result_valid_reg;
    assign voice_start  = voice_start_reg;
    assign voice_end    = voice_end_reg;
    assign active       = is_active_reg;

    // ---------------- register writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg   <= evad_pkg::WINDOW_LEN_RST;
            hangover_len_reg <= evad_pkg::HANGOVER_LEN_RST;
            energy_limit_reg <= evad_pkg::ENERGY_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                evad_pkg::REG_WINDOW_LEN:   window_len_reg   <= cfg_data[WIN_W-1:0];
                evad_pkg::REG_HANGOVER_LEN: hangover_len_reg <= cfg_data[HANG_W-1:0];
                evad_pkg::REG_ENERGY_LIMIT: energy_limit_reg <= cfg_data[SUM_W-1:0];
                default:                    ; // unused index, write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sample_valid)
        begin
            sample_reg <= sample;
        end
    end

    // square is never negative and never above 2^30
    assign product = sample_reg * sample_reg;
    assign sq      = product[SQ_W-1:0];

    // ---------------- accumulate, compare, hangover ----------------
    always_comb
    begin
        // effective window: zero acts as one, clamp at MAX_WINDOW
        if (window_len_reg == '0)
            win_eff = WIN_W'(1);
        else if (32'(window_len_reg) > 32'(MAX_WINDOW))
            win_eff = WIN_W'(MAX_WINDOW);
        else
            win_eff = window_len_reg;

        // saturating sum of squares
        sum_wide = {1'b0, energy_sum_reg} + (SUM_W+1)'(sq);
        sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

        fill_inc    = window_fill_reg + WIN_W'(1);
        window_done = (fill_inc >= win_eff);
        loud        = (sum_sat >= energy_limit_reg);

        energy_sum_next  = sum_sat;
        window_fill_next = fill_inc;
        hold_left_next   = hold_left_reg;
        is_active_next   = is_active_reg;
        voice_start_next = 1'b0;
        voice_end_next   = 1'b0;

        if (window_done)
        begin
            energy_sum_next  = '0;
            window_fill_next = '0;
            priority if (loud)
            begin
                hold_left_next = HOLD_W'(hangover_len_reg);
                is_active_next = 1'b1;
                voice_start_next = !is_active_reg;
            end
            else if (hold_left_reg != '0)
            begin
                // hangover runs down by one window, floored at zero
                if (hold_left_reg > HOLD_W'(win_eff))
                    hold_left_next = hold_left_reg - HOLD_W'(win_eff);
                else
                    hold_left_next = '0;
                is_active_next = 1'b1;
            end
            else if (is_active_reg)
            begin
                is_active_next = 1'b0;
                voice_end_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            energy_sum_reg   <= '0;
            window_fill_reg  <= '0;
            hold_left_reg    <= '0;
            is_active_reg    <= 1'b0;
            voice_start_reg  <= 1'b0;
            voice_end_reg    <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                energy_sum_reg  <= energy_sum_next;
                window_fill_reg <= window_fill_next;
                hold_left_reg   <= hold_left_next;
                is_active_reg   <= is_active_next;
                voice_start_reg <= voice_start_next;
                voice_end_reg   <= voice_end_next;
            end
        end
    end

endmodule

/* src/evad_checker.sv */
// ----------------------------------------------------------------------------
// evad_checker
// port-level checks of the voice activity detector, bound to the top level
// ----------------------------------------------------------------------------
module evad_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               sample_valid,
    input logic                               sample_stall,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic                               voice_start,
    input logic                               voice_end,
    input logic                               active
);

    // held result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid
            && $stable(voice_start) && $stable(voice_end) && $stable(active))
        else $error("held result changed");

    // a blocked result blocks the sample side too
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> sample_stall)
        else $error("sample side open while result is held");

    // start and end never share a window end
    a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(voice_start && voice_end))
        else $error("start and end in one result");

    // start leaves the block active, end leaves it inactive
    a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!voice_start || active) && (!voice_end || !active))
        else $error("event disagrees with activity flag");

    // no result without a sample that passed through the input register
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid, 2))
        else $error("result without a sample");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .voice_start  (voice_start),
    .voice_end    (voice_end),
    .active       (active)
);

/* sim/vad_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// vad_scoreboard_pkg
// expected-flag tracking for the voice activity detector: a cycle-free
// mirror of the window energy, hangover and activity state
// ----------------------------------------------------------------------------
package vad_scoreboard_pkg;

    import evad_pkg::*;

    typedef struct packed {
        logic began;
        logic ended;
        logic act;
    } vad_flags_t;

    localparam longint unsigned SUM_FULL = (64'd1 << SUM_W) - 64'd1;

    class vad_scoreboard;

        // register copies
        logic [WIN_W-1:0]  win_len;
        logic [HANG_W-1:0] hang_len;
        logic [SUM_W-1:0]  limit_sq;

        // detector state
        longint unsigned   sum_acc;
        logic [WIN_W-1:0]  fill_cnt;
        logic [HOLD_W-1:0] hold_cnt;
        logic              voiced;

        vad_flags_t        flags_due[$];
        int                results_seen;
        int                failures;

        function new();
            win_len      = WINDOW_LEN_RST;
            hang_len     = HANGOVER_LEN_RST;
            limit_sq     = ENERGY_LIMIT_RST;
            sum_acc      = 0;
            fill_cnt     = '0;
            hold_cnt     = '0;
            voiced       = 1'b0;
            results_seen = 0;
            failures     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW_LEN:   win_len  = data[WIN_W-1:0];
                REG_HANGOVER_LEN: hang_len = data[HANG_W-1:0];
                REG_ENERGY_LIMIT: limit_sq = data[SUM_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_sample(logic signed [SAMPLE_W-1:0] smp);
            longint unsigned sq;
            longint unsigned n;
            vad_flags_t      flags;
            sq    = longint'(smp) * longint'(smp);
            n     = (win_len == 0) ? 1 :
                    (win_len > MAX_WINDOW_DEFAULT) ? MAX_WINDOW_DEFAULT : win_len;
            flags = '0;
            if (sum_acc > SUM_FULL - sq)
                sum_acc = SUM_FULL;
            else
                sum_acc = sum_acc + sq;
            fill_cnt = fill_cnt + 1'b1;
            if (fill_cnt >= n)
            begin
                if (sum_acc >= limit_sq)
                begin
                    hold_cnt = HOLD_W'(hang_len);
                    if (!voiced)
                    begin
                        voiced      = 1'b1;
                        flags.began = 1'b1;
                    end
                end
                else if (hold_cnt != 0)
                begin
                    hold_cnt = (hold_cnt > n) ? hold_cnt - HOLD_W'(n) : '0;
                    voiced   = 1'b1;
                end
                else if (voiced)
                begin
                    voiced      = 1'b0;
                    flags.ended = 1'b1;
                end
                sum_acc  = 0;
                fill_cnt = '0;
            end
            flags.act = voiced;
            flags_due = {flags_due, flags};
        endfunction

        function void check_flags(logic began, logic ended, logic act);
            vad_flags_t want;
            results_seen++;
            if (flags_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
                return;
            end
            want = flags_due.pop_front();
            if (want != {began, ended, act})
            begin
                failures++;
                if (failures <= 10)
                    $display("result %0d: expected start %b end %b active %b, got %b %b %b",
                             results_seen, want.began, want.ended, want.act,
                             began, ended, act);
            end
        endfunction

    endclass

endpackage

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives audio samples and register writes into the voice activity detector
// under random valid and stall gaps, and compares every result transaction
// with the flags predicted by the scoreboard
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import evad_pkg::*;
    import vad_scoreboard_pkg::*;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int SENDER   = 0;
    localparam int RECEIVER = 1;

    localparam logic [SUM_W-1:0] ONE_SQUARE = SUM_W'(1) << 30;   // -1.0 squared
    localparam logic [SUM_W-1:0] LIMIT_FULL = {SUM_W{1'b1}};

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic                       voice_start;
    logic                       voice_end;
    logic                       active;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;

    vad_scoreboard sb = new();

    int samples_sent = 0;
    int calm_left[2] = '{0, 0};

    energy_voice_activity_detector i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .voice_start  (voice_start),
        .voice_end    (voice_end),
        .active       (active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // safety net against a hung handshake
    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // observe every handshake at the edge it completes on
    // result first, the sample accepted on the same edge belongs to a later result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_flags(voice_start, voice_end, active);
            if (sample_valid && !sample_stall)
                sb.add_sample(sample);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // idle gap per transaction, with occasional stretches of back-to-back traffic
    function automatic int pick_gap(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // result side: stall a random number of cycles, then take one transaction
    initial
    begin
        int hold;
        forever
        begin
            hold = pick_gap(RECEIVER);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    // valid stays up when the next sample follows without a gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap(SENDER);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        samples_sent++;
    endtask

    // every sample gives one result, so matching counts means the pipe is empty
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.results_seen != samples_sent) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // program all registers while idle, sometimes with junk above the window and
    // hangover fields, plus a write to the unused index that must change nothing
    task automatic program_regs(input logic [WIN_W-1:0]  win,
                                input logic [HANG_W-1:0] hang,
                                input logic [SUM_W-1:0]  lim);
        logic [63:0] junk;
        junk = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
        drain();
        write_reg(REG_WINDOW_LEN,   CFG_DATA_W'(win)  | CFG_DATA_W'(junk << WIN_W));
        write_reg(REG_HANGOVER_LEN, CFG_DATA_W'(hang) | CFG_DATA_W'(junk << HANG_W));
        write_reg(REG_ENERGY_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_UNUSED,       CFG_DATA_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    // one random setting followed by segments of quiet and loud audio
    task automatic run_phase(input int p);
        int unsigned                n;
        int unsigned                amp;
        int unsigned                seg_left;
        int unsigned                seg_amp;
        logic [WIN_W-1:0]           win;
        logic [HANG_W-1:0]          hang;
        logic [SUM_W-1:0]           lim;
        logic signed [SAMPLE_W-1:0] smp;
        case (p % 4)
            0:       win = WIN_W'($urandom_range(0, 2));
            1:       win = WIN_W'($urandom_range(3, 16));
            2:       win = WIN_W'($urandom_range(17, 64));
            default: win = WIN_W'($urandom_range(65, 300));
        endcase
        n   = (win == 0) ? 1 : 32'(win);
        amp = $urandom_range(64, 16384);
        if (p % 3 == 0)
            hang = '0;
        else if (p == 5)
            hang = '1;
        else
            hang = HANG_W'($urandom_range(0, 4 * n));
        // limit near the level of the chosen amplitude, or pinned to an extreme
        if (p == 2)
            lim = '0;
        else if (p == 7)
            lim = LIMIT_FULL;
        else
            lim = SUM_W'(longint'(n) * amp * amp);
        program_regs(win, hang, lim);
        seg_left = 0;
        seg_amp  = 0;
        repeat (145)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(1, 3 * n + 4);
                case ($urandom_range(0, 4))
                    0:       seg_amp = 0;
                    1:       seg_amp = amp / 4;
                    2:       seg_amp = amp;
                    3:       seg_amp = (amp * 2 > 32767) ? 32767 : amp * 2;
                    default: seg_amp = 32767;
                endcase
            end
            seg_left--;
            // a tenth of the samples are full-range noise
            if ($urandom_range(0, 9) == 0)
                smp = SAMPLE_W'($urandom);
            else
                smp = SAMPLE_W'(int'($urandom_range(0, 2 * seg_amp)) - int'(seg_amp));
            send_sample(smp);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-sample windows (length zero acts as one), no hangover,
        // limit at one full-scale square
        program_regs(13'd0, 20'd0, ONE_SQUARE);
        send_sample(-16'sd32768);   // loud, start
        send_sample(16'sd32767);    // just below the limit, end
        send_sample(16'sd0);
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        // hangover of three samples counted down one per window
        program_regs(13'd1, 20'd3, ONE_SQUARE);
        send_sample(-16'sd32768);
        repeat (4) send_sample(16'sd0);

        // hangover shorter than the window, subtraction clamps at zero
        program_regs(13'd2, 20'd1, ONE_SQUARE << 1);
        repeat (2) send_sample(-16'sd32768);
        repeat (4) send_sample(16'sd0);

        // window shrunk under a partly filled window ends it on the next sample
        program_regs(13'd100, 20'd0, ONE_SQUARE);
        repeat (5) send_sample(16'sd1000);
        program_regs(13'd3, 20'd0, ONE_SQUARE);
        send_sample(16'sd1000);

        for (int p = 0; p < 12; p++)
            run_phase(p);

        // back to the reset settings for the tail of the run
        program_regs(WINDOW_LEN_RST, HANGOVER_LEN_RST, ENERGY_LIMIT_RST);
        repeat (40) send_sample(SAMPLE_W'($urandom));

        drain();
        repeat (20) @(posedge clk);
        if (sb.flags_due.size() != 0)
            sb.failures++;
        if (sb.failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* filelist.f */
src/evad_pkg.sv
src/energy_voice_activity_detector.sv
src/evad_checker.sv
sim/vad_scoreboard_pkg.sv
sim/testbench.sv
